@@ sv/sobel_pkg.sv @@
// Shared types, constants and codes for the Sobel edge stream block.
package sobel_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int IMG_W_W = 11;
    localparam int OUT_W   = 10;
    // Width that holds both the clamped line length and the column count plus one.
    localparam int WCNT_W  = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;
    localparam int COL_XW  = (COL_W > OUT_W) ? COL_W : OUT_W;
    localparam int ROW_XW  = (ROW_W > OUT_W) ? ROW_W : OUT_W;

    localparam int MIN_WIDTH   = 3;
    localparam int LUMA_R      = 77;
    localparam int LUMA_G      = 150;
    localparam int LUMA_B      = 29;
    localparam int SQRT_STEPS  = 8;
    localparam int STEP_W      = $clog2(SQRT_STEPS);
    localparam logic [7:0] PIX_MAX = 8'hFF;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINARY_MODE = 2'd2;

    localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH = 11'd640;
    localparam logic [7:0]         RST_THRESHOLD   = 8'd80;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_start;
    } sobel_in_t;

    typedef struct packed {
        logic [7:0]       edge_value;
        logic [OUT_W-1:0] out_column;
        logic [OUT_W-1:0] out_row;
    } sobel_out_t;

    typedef struct packed {
        logic load;
        logic read;
        logic grad;
        logic sq_x;
        logic sq_y;
        logic root_step;
        logic push;
    } sobel_cmd_t;

    typedef struct packed {
        logic emit;
        logic out_free;
    } sobel_stat_t;

endpackage

@@ sv/sobel_dpath.sv @@
// Datapath: luma, line stores, window, gradients, square root and result register.
module sobel_dpath import sobel_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  sobel_in_t          s_pixel,
    input  logic [IMG_W_W-1:0] image_width,
    input  logic [7:0]         threshold,
    input  logic               binary_mode,
    input  sobel_cmd_t         cmd,
    output sobel_stat_t        stat,
    input  logic               m_ready,
    output logic               m_valid,
    output sobel_out_t         m_result
);

    logic [15:0]       line_mem [MAX_WIDTH];
    logic [15:0]       rd_data_reg;

    logic [7:0]        red_reg, green_reg, blue_reg;
    logic [7:0]        luma_reg;
    logic [COL_W-1:0]  col_reg, col_cnt_reg;
    logic [ROW_W-1:0]  row_reg, row_cnt_reg;
    logic [7:0]        win_reg [6];
    logic [9:0]        gx_reg, gy_reg;
    logic [19:0]       sum_reg;
    logic              sat_reg;
    logic [15:0]       v_reg, r_reg, bit_reg;
    logic              m_valid_reg;
    sobel_out_t        m_result_reg;

    logic [WCNT_W-1:0] img_w_ext, width_eff;
    logic [COL_W-1:0]  col_pre;
    logic [ROW_W-1:0]  row_pre;
    logic [WCNT_W-1:0] col_inc;
    logic [ROW_W:0]    row_inc;
    logic [15:0]       luma_sum;
    logic [7:0]        top, mid;
    logic [9:0]        right_sum, left_sum, bot_sum, upper_sum;
    logic [19:0]       gy_sq;
    logic [20:0]       total;
    logic [16:0]       trial;
    logic [7:0]        mag, edge_val;
    logic [COL_XW-1:0] col_out;
    logic [ROW_XW-1:0] row_out;

    // Line length clamped to the range the line stores can hold.
    always_comb begin
        img_w_ext = WCNT_W'(image_width);
        if (img_w_ext < WCNT_W'(MIN_WIDTH)) begin
            width_eff = WCNT_W'(MIN_WIDTH);
        end else if (img_w_ext > WCNT_W'(MAX_WIDTH)) begin
            width_eff = WCNT_W'(MAX_WIDTH);
        end else begin
            width_eff = img_w_ext;
        end
    end

    always_comb begin
        col_pre = s_pixel.frame_start ? '0 : col_cnt_reg;
        row_pre = s_pixel.frame_start ? '0 : row_cnt_reg;
        if (WCNT_W'(col_pre) >= width_eff) begin
            col_pre = '0;
        end
    end

    assign col_inc = WCNT_W'(col_reg) + WCNT_W'(1);
    assign row_inc = (ROW_W + 1)'(row_reg) + (ROW_W + 1)'(1);

    assign luma_sum = 16'(LUMA_R) * {8'd0, red_reg} + 16'(LUMA_G) * {8'd0, green_reg}
                    + 16'(LUMA_B) * {8'd0, blue_reg};

    assign top = rd_data_reg[15:8];
    assign mid = rd_data_reg[7:0];

    // Window columns: left is entries 0..2, middle is 3..5, right is top, mid, luma.
    assign right_sum = {2'd0, top} + {1'b0, mid, 1'b0} + {2'd0, luma_reg};
    assign left_sum  = {2'd0, win_reg[0]} + {1'b0, win_reg[1], 1'b0} + {2'd0, win_reg[2]};
    assign bot_sum   = {2'd0, win_reg[2]} + {1'b0, win_reg[5], 1'b0} + {2'd0, luma_reg};
    assign upper_sum = {2'd0, win_reg[0]} + {1'b0, win_reg[3], 1'b0} + {2'd0, top};

    assign gy_sq = 20'(gy_reg) * 20'(gy_reg);
    assign total = 21'(sum_reg) + 21'(gy_sq);
    assign trial = 17'(r_reg) + 17'(bit_reg);

    always_comb begin
        mag = sat_reg ? PIX_MAX : r_reg[7:0];
        if (binary_mode) begin
            edge_val = (mag > threshold) ? PIX_MAX : 8'd0;
        end else begin
            edge_val = mag;
        end
    end

    assign col_out = COL_XW'(col_reg) - COL_XW'(1);
    assign row_out = ROW_XW'(row_reg) - ROW_XW'(1);

    always_ff @(posedge aclk) begin
        if (cmd.grad) begin
            line_mem[col_reg] <= {mid, luma_reg};
        end
        if (cmd.read) begin
            rd_data_reg <= line_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (cmd.grad) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= luma_reg;
            if (col_inc >= width_eff) begin
                col_cnt_reg <= '0;
                row_cnt_reg <= (row_inc >= (ROW_W + 1)'(MAX_HEIGHT)) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                col_cnt_reg <= col_inc[COL_W-1:0];
                row_cnt_reg <= row_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            red_reg   <= s_pixel.red;
            green_reg <= s_pixel.green;
            blue_reg  <= s_pixel.blue;
            col_reg   <= col_pre;
            row_reg   <= row_pre;
        end
        if (cmd.read) begin
            luma_reg <= luma_sum[15:8];
        end
        if (cmd.grad) begin
            gx_reg <= (right_sum >= left_sum) ? right_sum - left_sum : left_sum - right_sum;
            gy_reg <= (bot_sum >= upper_sum) ? bot_sum - upper_sum : upper_sum - bot_sum;
        end
        if (cmd.sq_x) begin
            sum_reg <= 20'(gx_reg) * 20'(gx_reg);
        end
        if (cmd.sq_y) begin
            sat_reg <= (total[20:16] != 5'd0);
            v_reg   <= total[15:0];
            r_reg   <= '0;
            bit_reg <= 16'h4000;
        end
        // One result bit per step of the restoring square root.
        if (cmd.root_step) begin
            if ({1'b0, v_reg} >= trial) begin
                v_reg <= v_reg - trial[15:0];
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.push) begin
            m_result_reg.edge_value <= edge_val;
            m_result_reg.out_column <= col_out[OUT_W-1:0];
            m_result_reg.out_row    <= row_out[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign stat.emit     = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_result      = m_result_reg;

endmodule

@@ sv/sobel_ctrl.sv @@
// Controller state machine that sequences one pixel through the datapath.
module sobel_ctrl import sobel_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  sobel_stat_t stat,
    output sobel_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_GRAD,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_PUSH
    } state_t;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_GRAD;
            end
            ST_GRAD: begin
                cmd.grad   = 1'b1;
                state_next = stat.emit ? ST_SQX : ST_IDLE;
            end
            ST_SQX: begin
                cmd.sq_x   = 1'b1;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                cmd.sq_y   = 1'b1;
                step_next  = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                // Waits here only while the previous result is still unclaimed.
                if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

@@ sv/sobel_edge_stream.sv @@
// Top level of the Sobel edge stream block: configuration registers and the two sub-blocks.
//
//   channel  direction  handshake             payload
//   s_       in         s_valid / s_ready     s_pixel (sobel_in_t)
//   m_       out        m_valid / m_ready     m_result (sobel_out_t)
//   cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// The controller's sequence takes a pixel that gives no result through load, read and gradient;
// one that gives a result also goes through both squares, the 8-step square root unit and push.
// The output register holds a finished result, so the next pixel is taken
// while it waits; a result waits for m_ready only if the previous one is unclaimed.
// Reset is synchronous and active low; the line stores need no clearing pass.
module sobel_edge_stream import sobel_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sobel_in_t             s_pixel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sobel_out_t            m_result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [IMG_W_W-1:0] image_width_reg;
    logic [7:0]         threshold_reg;
    logic               binary_mode_reg;
    sobel_cmd_t         cmd;
    sobel_stat_t        stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= RST_IMAGE_WIDTH;
            threshold_reg   <= RST_THRESHOLD;
            binary_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH: image_width_reg <= cfg_data[IMG_W_W-1:0];
                CFG_THRESHOLD:   threshold_reg   <= cfg_data[7:0];
                CFG_BINARY_MODE: binary_mode_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    sobel_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sobel_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_pixel     (s_pixel),
        .image_width (image_width_reg),
        .threshold   (threshold_reg),
        .binary_mode (binary_mode_reg),
        .cmd         (cmd),
        .stat        (stat),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_result    (m_result)
    );

endmodule

@@ tb/tb_sobel_edge_stream.sv @@
// Self-checking testbench for the Sobel edge stream block: luma, 3x3 gradient, magnitude and binarization.
module tb_sobel_edge_stream import sobel_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W_RED       = 77;
    localparam int W_GREEN     = 150;
    localparam int W_BLUE      = 29;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 100;
    localparam int HOLD_CYCLES  = 300;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    sobel_in_t             s_pixel   = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    sobel_out_t            m_result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Mirror of the block's registers and pixel history.
    logic [IMG_W_W-1:0] mdl_width  = 11'd640;
    logic [7:0]         mdl_thresh = 8'd80;
    logic               mdl_binary = 1'b0;
    logic [7:0]         luma_up2 [MAX_WIDTH] = '{default: 8'd0};
    logic [7:0]         luma_up1 [MAX_WIDTH] = '{default: 8'd0};
    logic [7:0]         win_left [3] = '{default: 8'd0};
    logic [7:0]         win_mid  [3] = '{default: 8'd0};
    int unsigned        cur_col = 0;
    int unsigned        cur_row = 0;

    sobel_out_t  pending_edge_q [$];
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles   = 0;
    int unsigned rx_hold_req    = 0;
    int unsigned hold_left      = 0;
    bit          tx_idle_on     = 1'b1;
    bit          rx_idle_on     = 1'b1;
    int unsigned pix_lo         = 0;
    int unsigned pix_span       = 255;

    sobel_edge_stream i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic bit predict_sobel_pixel(input sobel_in_t px, output sobel_out_t res);
        int unsigned eff_w, y, top, mid, gx, gy, sum, mag, trial;
        int          a, b;
        bit          emit;
        eff_w = mdl_width;
        if (eff_w < 3) begin
            eff_w = 3;
        end else if (eff_w > MAX_WIDTH) begin
            eff_w = MAX_WIDTH;
        end
        if (px.frame_start) begin
            cur_col = 0;
            cur_row = 0;
        end
        // A narrower width written mid-line wraps the column without advancing the row.
        if (cur_col >= eff_w) begin
            cur_col = 0;
        end
        y   = (W_RED * px.red + W_GREEN * px.green + W_BLUE * px.blue) >> 8;
        top = luma_up2[cur_col];
        mid = luma_up1[cur_col];
        emit = (cur_row >= 2) && (cur_col >= 2);
        res  = '0;
        if (emit) begin
            a   = top + 2 * mid + y;
            b   = win_left[0] + 2 * win_left[1] + win_left[2];
            gx  = (a > b) ? a - b : b - a;
            a   = win_left[2] + 2 * win_mid[2] + y;
            b   = win_left[0] + 2 * win_mid[0] + top;
            gy  = (a > b) ? a - b : b - a;
            sum = gx * gx + gy * gy;
            if (sum >= 65536) begin
                mag = 255;
            end else begin
                mag = 0;
                for (int k = 7; k >= 0; k--) begin
                    trial = mag | (1 << k);
                    if (trial * trial <= sum) begin
                        mag = trial;
                    end
                end
            end
            if (mdl_binary) begin
                mag = (mag > mdl_thresh) ? 255 : 0;
            end
            res.edge_value = 8'(mag);
            res.out_column = OUT_W'(cur_col - 1);
            res.out_row    = OUT_W'(cur_row - 1);
        end
        win_left = win_mid;
        win_mid[0] = 8'(top);
        win_mid[1] = 8'(mid);
        win_mid[2] = 8'(y);
        luma_up2[cur_col] = 8'(mid);
        luma_up1[cur_col] = 8'(y);
        cur_col++;
        if (cur_col >= eff_w) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= MAX_HEIGHT) begin
                cur_row = 0;
            end
        end
        return emit;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 50) begin
            $display("%0d ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic send_pixel(input sobel_in_t px);
        sobel_out_t res;
        if (tx_idle_on && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        if (predict_sobel_pixel(px, res)) begin
            pending_edge_q.push_back(res);
        end
    endtask

    task automatic send_run(input int count, input bit first_fs, input int fs_pct);
        sobel_in_t px;
        for (int i = 0; i < count; i++) begin
            px.blue  = 8'(pix_lo + $urandom_range(pix_span));
            px.green = 8'(pix_lo + $urandom_range(pix_span));
            px.red   = 8'(pix_lo + $urandom_range(pix_span));
            px.frame_start = (i == 0) ? first_fs : ($urandom_range(99) < fs_pct);
            send_pixel(px);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH: begin
                mdl_width = val;
            end
            CFG_THRESHOLD: begin
                mdl_thresh = val[7:0];
            end
            CFG_BINARY_MODE: begin
                mdl_binary = val[0];
            end
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    // Pixels that give no result may still be in flight, so the wait goes on after the queue is empty.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_edge_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        pix_lo   = 0;
        pix_span = 255;
        // At the reset line length none of these pixels reaches an interior window.
        send_run(20, 1'b0, 0);
        wait_drained();
        // Only the line length is rewritten, so the output mode from reset is checked here.
        write_reg(CFG_IMAGE_WIDTH, 11'd4);
        send_run(16, 1'b1, 0);
        wait_drained();
    endtask

    task automatic test_directed_extremes();
        sobel_in_t dark, bright, px;
        sobel_in_t hues [5];
        dark    = '{8'd0, 8'd0, 8'd0, 1'b0};
        bright  = '{8'd255, 8'd255, 8'd255, 1'b0};
        hues[0] = '{8'd0, 8'd0, 8'd255, 1'b0};
        hues[1] = '{8'd0, 8'd255, 8'd0, 1'b0};
        hues[2] = '{8'd255, 8'd0, 8'd0, 1'b0};
        hues[3] = bright;
        hues[4] = dark;
        write_reg(CFG_IMAGE_WIDTH, 11'd5);
        write_reg(CFG_BINARY_MODE, 11'd0);
        // A hard vertical edge saturates, a flat patch gives zero, the last row mixes hues.
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 5; c++) begin
                if (r < 3) begin
                    px = (c < 2) ? dark : bright;
                end else begin
                    px = hues[c];
                end
                px.frame_start = (r == 0) && (c == 0);
                send_pixel(px);
            end
        end
        wait_drained();
    endtask

    task automatic test_binary_thresholds();
        logic [7:0] levels [3];
        levels = '{8'd0, 8'd255, 8'd100};
        write_reg(CFG_IMAGE_WIDTH, 11'd6);
        write_reg(CFG_BINARY_MODE, 11'd1);
        pix_lo   = 40;
        pix_span = 50;
        // First pass runs on the threshold left from reset.
        send_run(30, 1'b1, 0);
        wait_drained();
        foreach (levels[i]) begin
            write_reg(CFG_THRESHOLD, CFG_DATA_W'(levels[i]));
            send_run(30, 1'b1, 0);
            wait_drained();
        end
    endtask

    task automatic test_width_clamp();
        write_reg(CFG_BINARY_MODE, 11'd0);
        pix_lo   = 0;
        pix_span = 255;
        write_reg(CFG_IMAGE_WIDTH, 11'd0);
        send_run(12, 1'b1, 0);
        wait_drained();
        write_reg(CFG_IMAGE_WIDTH, 11'd2);
        send_run(12, 1'b1, 0);
        wait_drained();
        // Clamped to the full line store, so a short run gives no result.
        write_reg(CFG_IMAGE_WIDTH, 11'd2047);
        send_run(12, 1'b1, 0);
        wait_drained();
    endtask

    task automatic test_width_shrink_midline();
        pix_lo   = 0;
        pix_span = 255;
        write_reg(CFG_IMAGE_WIDTH, 11'd8);
        send_run(8 * 3 + 6, 1'b1, 0);
        wait_drained();
        // The column now sits past the new width and must wrap on the next pixel.
        write_reg(CFG_IMAGE_WIDTH, 11'd5);
        send_run(15, 1'b0, 0);
        wait_drained();
    endtask

    task automatic test_no_idle_stretch();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        pix_lo   = 60;
        pix_span = 80;
        write_reg(CFG_IMAGE_WIDTH, 11'd6);
        send_run(60, 1'b1, 0);
        wait_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        pix_lo   = 0;
        pix_span = 255;
        write_reg(CFG_IMAGE_WIDTH, 11'd4);
        rx_hold_req = HOLD_CYCLES;
        send_run(60, 1'b1, 0);
        wait_drained();
    endtask

    task automatic test_random_frames();
        int sent, w, n;
        sent = 0;
        for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
            w = ($urandom_range(7) == 0) ? $urandom_range(13, 24) : $urandom_range(3, 10);
            write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
            write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(2047)));
            write_reg(CFG_BINARY_MODE, CFG_DATA_W'($urandom_range(2047)));
            tx_idle_on = (phase != 2);
            rx_idle_on = (phase != 2);
            pix_span = $urandom_range(1) ? 255 : $urandom_range(60);
            pix_lo   = $urandom_range(255 - pix_span);
            n = w * $urandom_range(3, 6) + $urandom_range(w - 1);
            send_run(n, 1'b1, 3);
            sent += n;
            wait_drained();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (rx_hold_req != 0) begin
            hold_left   = rx_hold_req;
            rx_hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !rx_idle_on || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge aclk) begin : check_results
        sobel_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_edge_q.size() == 0) begin
                report_mismatch("result with none pending, row", 32'(m_result.out_row), 0);
            end else begin
                want = pending_edge_q.pop_front();
                if (m_result.edge_value !== want.edge_value) begin
                    report_mismatch("edge_value", 32'(m_result.edge_value),
                                    32'(want.edge_value));
                end
                if (m_result.out_column !== want.out_column) begin
                    report_mismatch("out_column", 32'(m_result.out_column),
                                    32'(want.out_column));
                end
                if (m_result.out_row !== want.out_row) begin
                    report_mismatch("out_row", 32'(m_result.out_row), 32'(want.out_row));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_extremes();
        test_binary_thresholds();
        test_width_clamp();
        test_width_shrink_midline();
        test_no_idle_stretch();
        test_output_backpressure();
        test_random_frames();
        wait_drained();
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
